/* rtl/core/i2c_master_transfer_sequencer_core_macros.svh */
// Assertion macros for the two-wire transfer sequencer core.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define I2CMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed on the following cycle");

// The consequent must hold in the same cycle as the antecedent.
`define I2CMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed in the same cycle");

`endif

/* rtl/core/i2cms_pkg.sv */
// Shared types and codes of the two-wire transfer sequencer core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 16;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_EVENT = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_START        = 4'd0,
        ST_REP_START    = 4'd1,
        ST_ADDR_W_ACK   = 4'd2,
        ST_DATA_TX_ACK  = 4'd3,
        ST_ADDR_R_ACK   = 4'd4,
        ST_DATA_RX_ACK  = 4'd5,
        ST_DATA_RX_NACK = 4'd6,
        ST_ARB_LOST     = 4'd7,
        ST_ADDR_W_NACK  = 4'd8,
        ST_ADDR_R_NACK  = 4'd9,
        ST_DATA_TX_NACK = 4'd10,
        ST_BUS_ERROR    = 4'd11,
        ST_OTHER        = 4'd12
    } bus_status_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_TX      = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_RESET   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_ADDR_W_NACK = 3'd1,
        ERR_ADDR_R_NACK = 3'd2,
        ERR_DATA_NACK   = 3'd3,
        ERR_BUS         = 3'd4,
        ERR_OTHER       = 3'd5
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  device_address;
        logic        read_not_write;
        logic [3:0]  length;
        logic [3:0]  byte_index;
        logic [7:0]  payload_byte;
        bus_status_t bus_status;
    } item_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       busy_res;
        logic       success;
        err_t       error_code;
    } result_t;

    typedef struct packed {
        logic busy;
        logic success;
        err_t error_code;
    } status_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } buf_wr_t;

endpackage

/* rtl/core/i2cms_buffer.sv */
// Byte buffer of the transfer sequencer: one write port, one registered read port.
// Depends on i2cms_pkg for the write request type.
`timescale 1ns / 1ps

module i2cms_buffer #(
    parameter int DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                     clk,
    input  i2cms_pkg::buf_wr_t       wr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
    end

    // A write in the same cycle to the entry being read is passed straight through.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/i2cms_engine.sv */
// Decision logic and transfer state of the sequencer: pointer, size, busy and status.
// Depends on i2cms_pkg; drives the write and read addresses of i2cms_buffer.
`timescale 1ns / 1ps

module i2cms_engine #(
    parameter int DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  i2cms_pkg::item_t         cur,
    input  i2cms_pkg::item_t         nxt,
    input  logic [7:0]               buf_data,
    output i2cms_pkg::buf_wr_t       wr,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    output i2cms_pkg::result_t       res,
    output i2cms_pkg::status_t       status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int PTR_W = $clog2(DEPTH + 1);
    localparam int CW    = (PTR_W + 1 > 5) ? PTR_W + 1 : 5;
    localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);

    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [PTR_W-1:0]      size_reg, size_next;
    logic                  busy_reg, busy_next;
    logic                  succ_reg, succ_next;
    i2cms_pkg::err_t       err_reg, err_next;

    logic [CW-1:0] ptr_w, ptr_inc_w, size_w, idx_w, p_w, p_inc_w, adv_w, adv_inc_w;
    logic [CW-1:0] len_sz_w, size_clamp_w, nxt_idx_w, rd_addr_w;
    logic          restart, nxt_restart;
    i2cms_pkg::cmd_t cmd;
    logic [7:0]    tx, rd;

    assign ptr_w     = CW'(ptr_reg);
    assign ptr_inc_w = ptr_w + CW'(1);
    assign size_w    = CW'(size_reg);
    assign idx_w     = CW'(cur.byte_index) + CW'(1);
    assign restart   = (cur.bus_status == i2cms_pkg::ST_START) ||
                       (cur.bus_status == i2cms_pkg::ST_REP_START);
    assign p_w       = restart ? '0 : ptr_w;
    assign p_inc_w   = p_w + CW'(1);
    // The pointer saturates at the buffer depth.
    assign adv_w     = (ptr_w < DEPTH_W) ? ptr_inc_w : ptr_w;
    assign adv_inc_w = adv_w + CW'(1);
    assign len_sz_w  = CW'(cur.length) + CW'(1);
    assign size_clamp_w = (len_sz_w > DEPTH_W) ? DEPTH_W : len_sz_w;

    always_comb
    begin
        ptr_next  = ptr_reg;
        size_next = size_reg;
        busy_next = busy_reg;
        succ_next = succ_reg;
        err_next  = err_reg;
        cmd       = i2cms_pkg::CMD_NONE;
        tx        = '0;
        rd        = '0;
        wr.en     = 1'b0;
        wr.data   = cur.payload_byte;
        wr_addr   = idx_w[AW-1:0];
        if (go)
        begin
            case (cur.kind)
                i2cms_pkg::KIND_LOAD:
                begin
                    wr.en = !busy_reg && (idx_w < DEPTH_W);
                end
                i2cms_pkg::KIND_START:
                begin
                    if (!busy_reg)
                    begin
                        wr.en     = 1'b1;
                        wr_addr   = '0;
                        wr.data   = {cur.device_address, cur.read_not_write};
                        size_next = size_clamp_w[PTR_W-1:0];
                        succ_next = 1'b0;
                        err_next  = i2cms_pkg::ERR_NONE;
                        busy_next = 1'b1;
                        cmd       = i2cms_pkg::CMD_START;
                    end
                end
                i2cms_pkg::KIND_EVENT:
                begin
                    if (busy_reg)
                    begin
                        case (cur.bus_status)
                            i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START,
                            i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_DATA_TX_ACK:
                            begin
                                ptr_next = p_w[PTR_W-1:0];
                                if ((p_w < size_w) && (p_w < DEPTH_W))
                                begin
                                    tx       = buf_data;
                                    ptr_next = p_inc_w[PTR_W-1:0];
                                    cmd      = i2cms_pkg::CMD_TX;
                                end
                                else
                                begin
                                    succ_next = 1'b1;
                                    busy_next = 1'b0;
                                    cmd       = i2cms_pkg::CMD_STOP;
                                end
                            end
                            i2cms_pkg::ST_ADDR_R_ACK:
                            begin
                                cmd = (ptr_inc_w < size_w) ? i2cms_pkg::CMD_RX_ACK
                                                           : i2cms_pkg::CMD_RX_NACK;
                            end
                            i2cms_pkg::ST_DATA_RX_ACK:
                            begin
                                wr.en    = (ptr_w < DEPTH_W);
                                wr_addr  = ptr_w[AW-1:0];
                                ptr_next = adv_w[PTR_W-1:0];
                                cmd = (adv_inc_w < size_w) ? i2cms_pkg::CMD_RX_ACK
                                                           : i2cms_pkg::CMD_RX_NACK;
                            end
                            i2cms_pkg::ST_DATA_RX_NACK:
                            begin
                                wr.en     = (ptr_w < DEPTH_W);
                                wr_addr   = ptr_w[AW-1:0];
                                succ_next = 1'b1;
                                busy_next = 1'b0;
                                cmd       = i2cms_pkg::CMD_STOP;
                            end
                            i2cms_pkg::ST_ARB_LOST:
                            begin
                                cmd = i2cms_pkg::CMD_START;
                            end
                            i2cms_pkg::ST_ADDR_W_NACK:
                            begin
                                err_next  = i2cms_pkg::ERR_ADDR_W_NACK;
                                busy_next = 1'b0;
                                cmd       = i2cms_pkg::CMD_RESET;
                            end
                            i2cms_pkg::ST_ADDR_R_NACK:
                            begin
                                err_next  = i2cms_pkg::ERR_ADDR_R_NACK;
                                busy_next = 1'b0;
                                cmd       = i2cms_pkg::CMD_RESET;
                            end
                            i2cms_pkg::ST_DATA_TX_NACK:
                            begin
                                err_next  = i2cms_pkg::ERR_DATA_NACK;
                                busy_next = 1'b0;
                                cmd       = i2cms_pkg::CMD_RESET;
                            end
                            i2cms_pkg::ST_BUS_ERROR:
                            begin
                                err_next  = i2cms_pkg::ERR_BUS;
                                busy_next = 1'b0;
                                cmd       = i2cms_pkg::CMD_RESET;
                            end
                            default:
                            begin
                                err_next  = i2cms_pkg::ERR_OTHER;
                                busy_next = 1'b0;
                                cmd       = i2cms_pkg::CMD_RESET;
                            end
                        endcase
                    end
                end
                i2cms_pkg::KIND_READ:
                begin
                    if (!busy_reg && succ_reg && (idx_w < DEPTH_W))
                    begin
                        rd = buf_data;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The buffer read for the following request is launched with the pointer
    // as this request leaves it, so its data is ready when that request is decided.
    assign nxt_idx_w   = CW'(nxt.byte_index) + CW'(1);
    assign nxt_restart = (nxt.bus_status == i2cms_pkg::ST_START) ||
                         (nxt.bus_status == i2cms_pkg::ST_REP_START);
    assign rd_addr_w   = (nxt.kind == i2cms_pkg::KIND_EVENT)
                         ? (nxt_restart ? '0 : CW'(ptr_next)) : nxt_idx_w;
    assign rd_addr     = rd_addr_w[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            size_reg <= '0;
            busy_reg <= 1'b0;
            succ_reg <= 1'b0;
            err_reg  <= i2cms_pkg::ERR_NONE;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            size_reg <= size_next;
            busy_reg <= busy_next;
            succ_reg <= succ_next;
            err_reg  <= err_next;
        end
    end

    assign res.command    = cmd;
    assign res.tx_byte    = tx;
    assign res.read_data  = rd;
    assign res.busy_res   = busy_next;
    assign res.success    = succ_next;
    assign res.error_code = err_next;

    assign status.busy       = busy_reg;
    assign status.success    = succ_reg;
    assign status.error_code = err_reg;

endmodule

/* rtl/core/i2c_master_transfer_sequencer_core.sv */
// Two-wire bus master transfer sequencer: top level with request and result registers.
// Depends on i2cms_pkg, i2cms_buffer, i2cms_engine and the core macros header.
//
// Requests enter on the s_ group: s_tuser carries the kind (load byte, start
// transfer, bus status event, read back) and s_tdata the remaining fields.
// Every request gives exactly one result on the m_ group, carrying the next
// bus command, the byte to transmit, read-back data and the transfer status.
// A request accepted into the request register is decided from it once the result
// register is free, and its result is registered there and shown on m_tvalid.
// One request per cycle is sustained while m_tready stays high; the figure is set
// by the single decision stage between the request register and the result
// register, with the buffer read launched as the request is accepted.
// While the result waits for m_tready, the request register still takes one
// more request; s_tready falls only when both registers are occupied and
// m_tready is low. After reset the block is idle, not busy, with no success
// and no error; buffer contents are undefined until written.
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_core_macros.svh"

module i2c_master_transfer_sequencer_core #(
    parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // device_address[6:0], read_not_write[7], length[11:8], byte_index[15:12],
    // payload_byte[23:16], bus_status[27:24], zero[31:28]
    input  logic [31:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // command[2:0], tx_byte[10:3], read_data[18:11], busy_res[19], success[20],
    // error_code[23:21]
    output logic [23:0] m_tdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    i2cms_pkg::item_t   in_item_reg;
    i2cms_pkg::item_t   nxt_item;
    logic               in_valid_reg, in_valid_next;
    i2cms_pkg::result_t out_reg;
    i2cms_pkg::result_t res;
    logic               out_valid_reg, out_valid_next;
    i2cms_pkg::status_t status;
    i2cms_pkg::buf_wr_t wr;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [7:0]         buf_data;
    logic               out_free, go, s_acc;

    assign nxt_item.kind           = i2cms_pkg::kind_t'(s_tuser);
    assign nxt_item.device_address = s_tdata[6:0];
    assign nxt_item.read_not_write = s_tdata[7];
    assign nxt_item.length         = s_tdata[11:8];
    assign nxt_item.byte_index     = s_tdata[15:12];
    assign nxt_item.payload_byte   = s_tdata[23:16];
    assign nxt_item.bus_status     = i2cms_pkg::bus_status_t'(s_tdata[27:24]);

    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_acc)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            in_item_reg <= nxt_item;
        end
        if (go)
        begin
            out_reg <= res;
        end
    end

    i2cms_engine #(
        .DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .cur      (in_item_reg),
        .nxt      (nxt_item),
        .buf_data (buf_data),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .res      (res),
        .status   (status)
    );

    i2cms_buffer #(
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (s_acc),
        .rd_addr (rd_addr),
        .rd_data (buf_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.error_code, out_reg.success, out_reg.busy_res,
                       out_reg.read_data, out_reg.tx_byte, out_reg.command};

    // A decided request always shows up as a result on the next cycle.
    `I2CMS_ASSERT_NEXT(a_go_gives_result, go, m_tvalid)
    // Busy can only be raised by a start request decided in the cycle before.
    `I2CMS_ASSERT_SAME(a_busy_from_start, $rose(status.busy),
        $past(go && (in_item_reg.kind == i2cms_pkg::KIND_START)))
    // Success is only reported once the transfer has finished.
    `I2CMS_ASSERT_SAME(a_success_idle, status.success, !status.busy)

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the two-wire bus master transfer sequencer core.
// Depends on i2cms_pkg and i2c_master_transfer_sequencer_core; predicts every result in-line.
`timescale 1ns / 1ps

module tb;

    localparam int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_REQUESTS = 330;
    localparam int LIMIT_CYCLES = 200000;

    // Request fields in s_tdata order, lowest bits last in the declaration.
    typedef struct packed {
        logic [3:0] bus_status;
        logic [7:0] payload_byte;
        logic [3:0] byte_index;
        logic [3:0] length;
        logic       read_not_write;
        logic [6:0] device_address;
    } req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Predicted sequencer state.
    logic [7:0]      buffer_q [BUFFER_DEPTH];
    logic [4:0]      ptr_q = '0;
    logic [4:0]      size_q = '0;
    logic            busy_q = 1'b0;
    logic            success_q = 1'b0;
    i2cms_pkg::err_t err_q = i2cms_pkg::ERR_NONE;
    bit              request_effective;

    i2cms_pkg::result_t pending_results [$];

    bit steady = 1'b0;
    bit hold_request = 1'b0;
    int failures = 0;
    int cycle_count = 0;
    int sent_requests = 0;
    int useful_items = 0;
    int checked_results = 0;
    int stop_count = 0;
    int reset_count = 0;
    int stalled_cycles = 0;

    i2c_master_transfer_sequencer_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("i2c_master_transfer_sequencer_core: mismatch");
            $finish;
        end
    end

    // Works out the result of one request and advances the predicted state.
    function automatic i2cms_pkg::result_t next_bus_result(input i2cms_pkg::kind_t kind,
                                                           input req_t req);
        i2cms_pkg::result_t r;
        int                 idx;
        r = '0;
        idx = int'(req.byte_index) + 1;
        request_effective = 1'b0;
        case (kind)
            i2cms_pkg::KIND_LOAD:
                if (!busy_q && idx < BUFFER_DEPTH)
                begin
                    buffer_q[AW'(idx)] = req.payload_byte;
                    request_effective = 1'b1;
                end
            i2cms_pkg::KIND_START:
                if (!busy_q)
                begin
                    buffer_q[0] = {req.device_address, req.read_not_write};
                    size_q = {1'b0, req.length} + 5'd1;
                    if (size_q > BUFFER_DEPTH)
                        size_q = 5'(BUFFER_DEPTH);
                    success_q = 1'b0;
                    err_q = i2cms_pkg::ERR_NONE;
                    busy_q = 1'b1;
                    r.command = i2cms_pkg::CMD_START;
                    request_effective = 1'b1;
                end
            i2cms_pkg::KIND_EVENT:
                if (busy_q)
                begin
                    request_effective = 1'b1;
                    // A start or repeated start rewinds to the address byte.
                    if (req.bus_status == i2cms_pkg::ST_START ||
                        req.bus_status == i2cms_pkg::ST_REP_START)
                        ptr_q = '0;
                    case (req.bus_status)
                        i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START,
                        i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_DATA_TX_ACK:
                            if (ptr_q < size_q && ptr_q < BUFFER_DEPTH)
                            begin
                                r.command = i2cms_pkg::CMD_TX;
                                r.tx_byte = buffer_q[ptr_q[AW-1:0]];
                                ptr_q = ptr_q + 5'd1;
                            end
                            else
                            begin
                                r.command = i2cms_pkg::CMD_STOP;
                                success_q = 1'b1;
                                busy_q = 1'b0;
                            end
                        i2cms_pkg::ST_DATA_RX_ACK:
                        begin
                            if (ptr_q < BUFFER_DEPTH)
                            begin
                                buffer_q[ptr_q[AW-1:0]] = req.payload_byte;
                                ptr_q = ptr_q + 5'd1;
                            end
                            r.command = (ptr_q + 5'd1 < size_q) ? i2cms_pkg::CMD_RX_ACK
                                                                : i2cms_pkg::CMD_RX_NACK;
                        end
                        i2cms_pkg::ST_ADDR_R_ACK:
                            r.command = (ptr_q + 5'd1 < size_q) ? i2cms_pkg::CMD_RX_ACK
                                                                : i2cms_pkg::CMD_RX_NACK;
                        i2cms_pkg::ST_DATA_RX_NACK:
                        begin
                            if (ptr_q < BUFFER_DEPTH)
                                buffer_q[ptr_q[AW-1:0]] = req.payload_byte;
                            r.command = i2cms_pkg::CMD_STOP;
                            success_q = 1'b1;
                            busy_q = 1'b0;
                        end
                        i2cms_pkg::ST_ARB_LOST:
                            r.command = i2cms_pkg::CMD_START;
                        default:
                        begin
                            case (req.bus_status)
                                i2cms_pkg::ST_ADDR_W_NACK:  err_q = i2cms_pkg::ERR_ADDR_W_NACK;
                                i2cms_pkg::ST_ADDR_R_NACK:  err_q = i2cms_pkg::ERR_ADDR_R_NACK;
                                i2cms_pkg::ST_DATA_TX_NACK: err_q = i2cms_pkg::ERR_DATA_NACK;
                                i2cms_pkg::ST_BUS_ERROR:    err_q = i2cms_pkg::ERR_BUS;
                                default:                    err_q = i2cms_pkg::ERR_OTHER;
                            endcase
                            busy_q = 1'b0;
                            r.command = i2cms_pkg::CMD_RESET;
                        end
                    endcase
                end
            default:
                if (!busy_q)
                begin
                    request_effective = 1'b1;
                    if (success_q && idx < BUFFER_DEPTH)
                        r.read_data = buffer_q[AW'(idx)];
                end
        endcase
        r.busy_res = busy_q;
        r.success = success_q;
        r.error_code = err_q;
        return r;
    endfunction

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        i2cms_pkg::result_t got;
        i2cms_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.command = i2cms_pkg::cmd_t'(m_tdata[2:0]);
            got.tx_byte = m_tdata[10:3];
            got.read_data = m_tdata[18:11];
            got.busy_res = m_tdata[19];
            got.success = m_tdata[20];
            got.error_code = i2cms_pkg::err_t'(m_tdata[23:21]);
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with no request outstanding:", $time);
                $display("    cmd=%0d tx=%02h rd=%02h busy=%0b ok=%0b err=%0d",
                         got.command, got.tx_byte, got.read_data, got.busy_res,
                         got.success, got.error_code);
            end
            else
            begin
                want = pending_results.pop_front();
                checked_results++;
                if (want.command == i2cms_pkg::CMD_STOP)
                    stop_count++;
                if (want.command == i2cms_pkg::CMD_RESET)
                    reset_count++;
                if (got !== want)
                begin
                    failures++;
                    $display("%0t: expected cmd=%0d tx=%02h rd=%02h busy=%0b ok=%0b err=%0d",
                             $time, want.command, want.tx_byte, want.read_data,
                             want.busy_res, want.success, want.error_code);
                    $display("%0t: got      cmd=%0d tx=%02h rd=%02h busy=%0b ok=%0b err=%0d",
                             $time, got.command, got.tx_byte, got.read_data,
                             got.busy_res, got.success, got.error_code);
                end
            end
        end
    end

    // Result side: random idling, a quiet stretch, and a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 35);
        end
    end

    task automatic send_request(input i2cms_pkg::kind_t kind, input req_t req,
                                output i2cms_pkg::result_t r);
        if (!steady && $urandom_range(99) < 35)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1))
                @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0000, req};
        @(posedge clk);
        while (!s_tready)
        begin
            stalled_cycles++;
            @(posedge clk);
        end
        r = next_bus_result(kind, req);
        pending_results.push_back(r);
        sent_requests++;
        if (request_effective)
            useful_items++;
    endtask

    task automatic send_event(input logic [3:0] status, output i2cms_pkg::result_t r);
        req_t req;
        req = 28'($urandom);
        req.bus_status = status;
        send_request(i2cms_pkg::KIND_EVENT, req, r);
    endtask

    task automatic start_transfer(input logic rnw, input logic [3:0] len,
                                  output i2cms_pkg::result_t r);
        req_t req;
        req = 28'($urandom);
        req.read_not_write = rnw;
        req.length = len;
        send_request(i2cms_pkg::KIND_START, req, r);
    endtask

    task automatic send_indexed(input i2cms_pkg::kind_t kind, input logic [3:0] idx,
                                input logic [7:0] data);
        req_t               req;
        i2cms_pkg::result_t r;
        req = 28'($urandom);
        req.byte_index = idx;
        req.payload_byte = data;
        send_request(kind, req, r);
    endtask

    task automatic wait_for_results;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // One transfer driven by the bus events a well-behaved interface would report;
    // fault_pct sets how often a broken status or a misplaced request is injected.
    task automatic run_transfer(input logic rnw, input logic [3:0] len, input int fault_pct);
        i2cms_pkg::result_t r;
        req_t               req;
        i2cms_pkg::cmd_t    next_cmd;
        logic [3:0]         status;
        bit                 address_pending;
        int                 guard;
        start_transfer(rnw, len, r);
        next_cmd = r.command;
        address_pending = 1'b0;
        guard = 0;
        while (r.busy_res && guard < 48)
        begin
            guard++;
            if ($urandom_range(99) < fault_pct / 2)
            begin
                req = 28'($urandom);
                case ($urandom_range(2))
                    0:       send_request(i2cms_pkg::KIND_LOAD, req, r);
                    1:       send_request(i2cms_pkg::KIND_START, req, r);
                    default: send_request(i2cms_pkg::KIND_READ, req, r);
                endcase
            end
            else
            begin
                case (next_cmd)
                    i2cms_pkg::CMD_START:
                        status = $urandom_range(1) ? i2cms_pkg::ST_START
                                                   : i2cms_pkg::ST_REP_START;
                    i2cms_pkg::CMD_TX:
                        if (address_pending)
                            status = rnw ? i2cms_pkg::ST_ADDR_R_ACK : i2cms_pkg::ST_ADDR_W_ACK;
                        else
                            status = i2cms_pkg::ST_DATA_TX_ACK;
                    i2cms_pkg::CMD_RX_ACK:  status = i2cms_pkg::ST_DATA_RX_ACK;
                    i2cms_pkg::CMD_RX_NACK: status = i2cms_pkg::ST_DATA_RX_NACK;
                    default:                status = i2cms_pkg::ST_OTHER;
                endcase
                if ($urandom_range(99) < fault_pct)
                    status = 4'($urandom_range(15));
                if (status == i2cms_pkg::ST_START || status == i2cms_pkg::ST_REP_START)
                    address_pending = 1'b1;
                else if (status == i2cms_pkg::ST_ADDR_W_ACK ||
                         status == i2cms_pkg::ST_ADDR_R_ACK)
                    address_pending = 1'b0;
                send_event(status, r);
                if (r.command != i2cms_pkg::CMD_NONE)
                    next_cmd = r.command;
            end
        end
        if (r.busy_res)
            send_event(i2cms_pkg::ST_BUS_ERROR, r);
    endtask

    // Ignored requests while idle (a read and an event), then loads to buffer entries 1 to 15.
    task automatic test_idle_requests;
        i2cms_pkg::result_t r;
        int                 i;
        send_indexed(i2cms_pkg::KIND_READ, 4'd0, 8'h00);
        send_event(i2cms_pkg::ST_DATA_TX_ACK, r);
        for (i = 0; i < BUFFER_DEPTH - 1; i++)
            send_indexed(i2cms_pkg::KIND_LOAD, 4'(i),
                         (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
        // Index fifteen points one past the buffer and must be dropped.
        send_indexed(i2cms_pkg::KIND_LOAD, 4'd15, 8'h5A);
        wait_for_results();
    endtask

    task automatic test_write_transfers;
        i2cms_pkg::result_t r;
        start_transfer(1'b0, 4'd0, r);
        send_event(i2cms_pkg::ST_START, r);
        send_event(i2cms_pkg::ST_ADDR_W_ACK, r);
        start_transfer(1'b0, 4'd2, r);
        send_indexed(i2cms_pkg::KIND_LOAD, 4'd3, 8'hC3);
        send_indexed(i2cms_pkg::KIND_READ, 4'd0, 8'h00);
        send_event(i2cms_pkg::ST_REP_START, r);
        send_event(i2cms_pkg::ST_ADDR_W_ACK, r);
        send_event(i2cms_pkg::ST_DATA_TX_ACK, r);
        send_event(i2cms_pkg::ST_DATA_TX_NACK, r);
        wait_for_results();
    endtask

    task automatic test_read_transfers;
        i2cms_pkg::result_t r;
        start_transfer(1'b1, 4'd0, r);
        send_event(i2cms_pkg::ST_START, r);
        send_event(i2cms_pkg::ST_ADDR_R_ACK, r);
        send_event(i2cms_pkg::ST_DATA_RX_NACK, r);
        send_indexed(i2cms_pkg::KIND_READ, 4'd0, 8'h00);
        send_indexed(i2cms_pkg::KIND_READ, 4'd15, 8'h00);
        run_transfer(1'b1, 4'd15, 0);
        send_indexed(i2cms_pkg::KIND_READ, 4'd14, 8'h00);
        start_transfer(1'b1, 4'd3, r);
        send_event(i2cms_pkg::ST_START, r);
        send_event(i2cms_pkg::ST_ADDR_R_NACK, r);
        send_indexed(i2cms_pkg::KIND_READ, 4'd1, 8'h00);
        wait_for_results();
    endtask

    task automatic test_error_statuses;
        i2cms_pkg::result_t r;
        start_transfer(1'b0, 4'd5, r);
        send_event(i2cms_pkg::ST_ARB_LOST, r);
        send_event(i2cms_pkg::ST_REP_START, r);
        send_event(i2cms_pkg::ST_ADDR_W_NACK, r);
        start_transfer(1'b0, 4'd1, r);
        send_event(i2cms_pkg::ST_BUS_ERROR, r);
        start_transfer(1'b1, 4'd1, r);
        send_event(i2cms_pkg::ST_OTHER, r);
        start_transfer(1'b1, 4'd7, r);
        send_event(4'd15, r);
        wait_for_results();
    endtask

    // The result side stops for a long stretch while a full transfer is offered.
    task automatic test_result_hold_off;
        int i;
        steady = 1'b1;
        hold_request = 1'b1;
        run_transfer(1'b0, 4'd15, 0);
        for (i = 0; i < 6; i++)
            send_indexed(i2cms_pkg::KIND_READ, 4'($urandom_range(15)), 8'h00);
        steady = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_traffic;
        i2cms_pkg::result_t r;
        req_t               req;
        int                 target;
        int                 base;
        int                 i;
        base = useful_items;
        target = base + RANDOM_REQUESTS;
        while (useful_items < target)
        begin
            steady = (useful_items - base >= 150) && (useful_items - base < 230);
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                    run_transfer(1'($urandom_range(1)), 4'($urandom_range(15)), 12);
                11, 12, 13:
                    for (i = 0; i < $urandom_range(1, 4); i++)
                        send_indexed(i2cms_pkg::KIND_LOAD, 4'($urandom_range(15)),
                                     8'($urandom));
                14, 15, 16:
                    for (i = 0; i < $urandom_range(1, 4); i++)
                        send_indexed(i2cms_pkg::KIND_READ, 4'($urandom_range(15)),
                                     8'($urandom));
                17:
                    wait_for_results();
                default:
                begin
                    req = 28'($urandom);
                    send_request(i2cms_pkg::kind_t'($urandom_range(3)), req, r);
                end
            endcase
        end
        steady = 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_requests();
        test_write_transfers();
        test_read_transfers();
        test_error_statuses();
        test_result_hold_off();
        test_random_traffic();
        repeat (8)
            @(posedge clk);
        $display("Covered %0d requests (%0d acted on) and %0d checked results.",
                 sent_requests, useful_items, checked_results);
        $display("Transfers ended by stop: %0d, by interface reset: %0d; input stalled %0d cycles.",
                 stop_count, reset_count, stalled_cycles);
        if (failures == 0)
            $display("i2c_master_transfer_sequencer_core: match");
        else
            $display("i2c_master_transfer_sequencer_core: mismatch");
        $finish;
    end

endmodule
